// ===== hdl/fdxb_pkg.sv =====
// Shared constants, widths and CRC helpers for the FDX-B frame modulator.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package fdxb_pkg;

    // Payload field widths
    localparam int ID_W    = 64;
    localparam int EXTRA_W = 24;
    localparam int HALF_W  = 32;
    localparam int INDEX_W = 3;
    localparam int CRC_W   = 16;

    // Frame layout
    localparam int WORD_LEVELS  = 32;
    localparam int FRAME_BITS   = 128;
    localparam int FRAME_LEVELS = 2 * FRAME_BITS;
    localparam int MAX_WORDS    = 8;
    localparam int SYNC_ONE     = 10;
    localparam int SLOT_BASE    = 11;
    localparam int SLOT_SPAN    = 9;
    localparam int NUM_SLOTS    = 13;
    localparam int SLOT_VEC_W   = 8 * NUM_SLOTS;

    // Word count per frame, capped
    localparam int RAW_WORDS = (FRAME_LEVELS + WORD_LEVELS - 1) / WORD_LEVELS;
    localparam int NUM_WORDS = (RAW_WORDS > MAX_WORDS) ? MAX_WORDS : RAW_WORDS;
    localparam int CNT_W     = $clog2(NUM_WORDS);
    localparam int PAD_W     = NUM_WORDS * WORD_LEVELS;
    localparam int LEVEL_W   = (PAD_W > FRAME_LEVELS) ? PAD_W : FRAME_LEVELS;

    // CRC
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'h0000;

    // One byte through the CRC register, MSB first
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c_in,
                                                  input logic [7:0]       d);
        logic [CRC_W-1:0] c;
        c = c_in ^ {d, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [CRC_W-1:0] bit_rev16(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        for (int b = 0; b < CRC_W; b++) begin
            r[CRC_W-1-b] = v[b];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/fdxb_if.sv =====
// Valid/ready channel interfaces for tag records and modulated words.
// Depends on fdxb_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface fdxb_rec_if import fdxb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ID_W-1:0]    id_bytes;
    logic [EXTRA_W-1:0] extra_bytes;

    modport source (output valid, output id_bytes, output extra_bytes, input ready);
    modport sink   (input valid, input id_bytes, input extra_bytes, output ready);
endinterface

interface fdxb_word_if import fdxb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [HALF_W-1:0]  half_levels;
    logic [INDEX_W-1:0] word_index;
    logic [CRC_W-1:0]   frame_crc;
    logic               last_word;

    modport source (output valid, output half_levels, output word_index,
                    output frame_crc, output last_word, input ready);
    modport sink   (input valid, input half_levels, input word_index,
                    input frame_crc, input last_word, output ready);
endinterface

`default_nettype wire

// ===== hdl/fdx_b_frame_modulator_core.sv =====
// FDX-B frame modulator: CRC, frame build, biphase coding and word serializer.
// Depends on fdxb_pkg and the channel interfaces in fdxb_if.sv.
//
// Usage:
//   i_rec  takes one tag record per request (8 identity bytes, 3 extra bytes).
//   o_word returns the biphase-coded frame as NUM_WORDS words (8 by default)
//          of 32 half-bit levels, earliest level in the MSB, each tagged with
//          its index, the inserted CRC and a last-word flag.
//   Path: a record passes the registers two CRC stages, frame build, level
//   coding and serializer, in that order, before its first word is valid.
//   Rate: set by the serializer, which drives one word per cycle while
//   o_word.ready is high; the four stages ahead of it buffer up to four
//   further records, so a new record is taken while a frame is still going out.
//   Stall: when o_word.ready is low the current word holds, the stages fill,
//   and i_rec.ready drops once all are full. Nothing is lost or repeated.
//   Reset: synchronous, active low; clears all stage valid bits and the word
//   counter. No output is valid in the cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module fdx_b_frame_modulator_core import fdxb_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    fdxb_rec_if.sink   i_rec,
    fdxb_word_if.source o_word
);

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_WORDS - 1);

    // Stage registers
    logic                   r_s1_valid;
    logic [ID_W-1:0]        r_s1_id;
    logic [EXTRA_W-1:0]     r_s1_ex;
    logic [CRC_W-1:0]       r_s1_crc;

    logic                   r_s2_valid;
    logic [ID_W-1:0]        r_s2_id;
    logic [EXTRA_W-1:0]     r_s2_ex;
    logic [CRC_W-1:0]       r_s2_crc;

    logic                   r_s3_valid;
    logic [FRAME_BITS-1:0]  r_s3_frame;
    logic [FRAME_BITS-1:0]  r_s3_lp;
    logic [NUM_SLOTS-1:0]   r_s3_spar;
    logic [CRC_W-1:0]       r_s3_crc;

    logic                   r_s4_valid;
    logic [LEVEL_W-1:0]     r_s4_lv;
    logic [CRC_W-1:0]       r_s4_crc;

    logic                   r_s5_valid;
    logic [LEVEL_W-1:0]     r_s5_sr;
    logic [CRC_W-1:0]       r_s5_crc;
    logic [CNT_W-1:0]       r_cnt;

    // Next values
    logic [CRC_W-1:0]       n_s1_crc;
    logic [CRC_W-1:0]       n_s2_crc;
    logic [FRAME_BITS-1:0]  n_s3_frame;
    logic [FRAME_BITS-1:0]  n_s3_lp;
    logic [NUM_SLOTS-1:0]   n_s3_spar;
    logic [LEVEL_W-1:0]     n_s4_lv;

    // Flow control
    logic s1_ready, s2_ready, s3_ready, s4_ready, s5_load_ok, out_take, s5_last;

    assign s5_last    = (r_cnt == LAST_CNT);
    assign out_take   = r_s5_valid && o_word.ready;
    assign s5_load_ok = !r_s5_valid || (o_word.ready && s5_last);
    assign s4_ready   = !r_s4_valid || s5_load_ok;
    assign s3_ready   = !r_s3_valid || s4_ready;
    assign s2_ready   = !r_s2_valid || s3_ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign i_rec.ready = s1_ready;

    // Stage 1: CRC over identity bytes 0..3
    always_comb begin
        n_s1_crc = CRC_INIT;
        for (int k = 0; k < 4; k++) begin
            n_s1_crc = crc_byte(n_s1_crc, i_rec.id_bytes[8*k +: 8]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_rec.valid;
        end
        if (s1_ready && i_rec.valid) begin
            r_s1_id  <= i_rec.id_bytes;
            r_s1_ex  <= i_rec.extra_bytes;
            r_s1_crc <= n_s1_crc;
        end
    end

    // Stage 2: CRC over bytes 4..7, then bit reversal
    always_comb begin
        logic [CRC_W-1:0] c;
        c = r_s1_crc;
        for (int k = 4; k < 8; k++) begin
            c = crc_byte(c, r_s1_id[8*k +: 8]);
        end
        n_s2_crc = bit_rev16(c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2_id  <= r_s1_id;
            r_s2_ex  <= r_s1_ex;
            r_s2_crc <= n_s2_crc;
        end
    end

    // Stage 3: frame bits, parity prefix within each slot, slot parity
    always_comb begin
        logic [SLOT_VEC_W-1:0] slots;
        logic                  par;
        int                    idx;
        slots      = {r_s2_ex, r_s2_crc, r_s2_id};
        n_s3_frame = '0;
        n_s3_lp    = '0;
        n_s3_spar  = '0;
        n_s3_frame[SYNC_ONE] = 1'b1;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            par = 1'b0;
            for (int b = 0; b < 8; b++) begin
                idx = SLOT_BASE + SLOT_SPAN * k + b;
                n_s3_frame[idx] = slots[8*k + b];
                n_s3_lp[idx]    = par;
                par             = par ^ slots[8*k + b];
            end
            // control one after each slot
            idx = SLOT_BASE + SLOT_SPAN * k + 8;
            n_s3_frame[idx] = 1'b1;
            n_s3_lp[idx]    = par;
            n_s3_spar[k]    = ~par;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (s3_ready) begin
            r_s3_valid <= r_s2_valid;
        end
        if (s3_ready && r_s2_valid) begin
            r_s3_frame <= n_s3_frame;
            r_s3_lp    <= n_s3_lp;
            r_s3_spar  <= n_s3_spar;
            r_s3_crc   <= r_s2_crc;
        end
    end

    // Stage 4: slot carries give the level before each bit; expand to half levels.
    // Level before bit i is the parity of all earlier frame bits; the sync
    // section contributes a single one.
    always_comb begin
        logic [FRAME_BITS-1:0] lvl;
        logic                  c;
        int                    idx;
        lvl = r_s3_lp;
        c   = 1'b1;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            for (int b = 0; b < SLOT_SPAN; b++) begin
                idx = SLOT_BASE + SLOT_SPAN * k + b;
                lvl[idx] = r_s3_lp[idx] ^ c;
            end
            c = c ^ r_s3_spar[k];
        end
        n_s4_lv = '0;
        for (int i = 0; i < FRAME_BITS; i++) begin
            n_s4_lv[LEVEL_W-1-2*i] = ~lvl[i];
            n_s4_lv[LEVEL_W-2-2*i] = lvl[i] ^ r_s3_frame[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (s4_ready) begin
            r_s4_valid <= r_s3_valid;
        end
        if (s4_ready && r_s3_valid) begin
            r_s4_lv  <= n_s4_lv;
            r_s4_crc <= r_s3_crc;
        end
    end

    // Stage 5: word serializer, NUM_WORDS words per record, advancing on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
            r_cnt      <= '0;
        end else if (s5_load_ok) begin
            r_s5_valid <= r_s4_valid;
            r_cnt      <= '0;
        end else if (out_take) begin
            r_cnt <= r_cnt + 1'b1;
        end
        if (s5_load_ok && r_s4_valid) begin
            r_s5_sr  <= r_s4_lv;
            r_s5_crc <= r_s4_crc;
        end else if (!s5_load_ok && out_take) begin
            r_s5_sr <= r_s5_sr << WORD_LEVELS;
        end
    end

    assign o_word.valid       = r_s5_valid;
    assign o_word.half_levels = HALF_W'(r_s5_sr[LEVEL_W-1 -: WORD_LEVELS]);
    assign o_word.word_index  = INDEX_W'(r_cnt);
    assign o_word.frame_crc   = r_s5_crc;
    assign o_word.last_word   = s5_last;

    // Checks
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_word.valid && o_word.ready && !o_word.last_word) |=>
        (o_word.valid &&
         o_word.word_index == INDEX_W'($past(o_word.word_index) + 1'b1)))
        else $error("word index did not advance within a frame");

    a_crc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_word.valid && o_word.ready && !o_word.last_word) |=>
        (o_word.frame_crc == $past(o_word.frame_crc)))
        else $error("frame CRC changed within a frame");

    a_new_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_word.valid && o_word.ready && o_word.last_word) |=>
        (!o_word.valid || o_word.word_index == '0))
        else $error("new frame did not start at word zero");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_word.valid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire
